// ===== rtl/albs_pkg.sv =====
`default_nettype none
package albs_pkg;

  localparam int NOISE_FRAC = 12;
  localparam int EXP_FRAC   = 30;
  localparam int TAYLOR_N   = 20;
  localparam int PC_W       = 6;
  localparam logic [PC_W-1:0] PC_STEP  = 6'd0;
  localparam logic [PC_W-1:0] PC_START = 6'd16;

  localparam logic [2:0] REG_FRIC  = 3'd0;
  localparam logic [2:0] REG_TEMP  = 3'd1;
  localparam logic [2:0] REG_BASE  = 3'd2;
  localparam logic [2:0] REG_MIN   = 3'd3;
  localparam logic [2:0] REG_MAX   = 3'd4;
  localparam logic [2:0] REG_START = 3'd5;
  localparam logic [2:0] REG_FINAL = 3'd6;

  typedef enum logic [14:0] {
    S_IDLE = 15'b000000000000001,
    S_FETCH = 15'b000000000000010,
    S_MUL  = 15'b000000000000100,
    S_MULR = 15'b000000000001000,
    S_DIVL = 15'b000000000010000,
    S_DIVW = 15'b000000000100000,
    S_SQM  = 15'b000000001000000,
    S_SQC  = 15'b000000010000000,
    S_TMUL = 15'b000000100000000,
    S_TDL  = 15'b000001000000000,
    S_TDW  = 15'b000010000000000,
    S_EXL  = 15'b000100000000000,
    S_EXM  = 15'b001000000000000,
    S_EXR  = 15'b010000000000000,
    S_OUT  = 15'b100000000000000
  } state_t;

  typedef enum logic [3:0] {
    OP_MUL, OP_MULN, OP_DIV, OP_SQRT, OP_EXP,
    OP_ADD, OP_SUB, OP_HALF, OP_UP, OP_NEG, OP_TADD
  } op_t;

  typedef enum logic [4:0] {
    R_POS, R_MOM, R_FRC, R_STP, R_TIM, R_HH, R_C, R_S, R_T0, R_T1,
    R_ONE, R_FRIC, R_TEMP, R_BASE, R_MIN, R_MAX, R_NOISE, R_ZERO
  } reg_sel_t;

  typedef struct packed {
    op_t      op;
    reg_sel_t a;
    reg_sel_t b;
    reg_sel_t d;
    logic     step_only;
    logic     last;
  } uop_t;

  typedef struct packed {
    logic start;
    logic short_mode;
  } div_ctl_t;

  function automatic uop_t mk(input op_t op, input reg_sel_t a, input reg_sel_t b,
                              input reg_sel_t d, input logic so, input logic last);
    uop_t r;
    r.op = op;
    r.a = a;
    r.b = b;
    r.d = d;
    r.step_only = so;
    r.last = last;
    return r;
  endfunction

  // B-A-O-A, then force, the second B and step size; a start item enters at PC_START
  function automatic uop_t uop_at(input logic [PC_W-1:0] pc);
    uop_t r;
    unique case (pc)
      6'd0:  r = mk(OP_HALF, R_STP,  R_ZERO,  R_HH,   1'b1, 1'b0);
      6'd1:  r = mk(OP_MUL,  R_HH,   R_FRC,   R_T0,   1'b1, 1'b0);
      6'd2:  r = mk(OP_ADD,  R_MOM,  R_T0,    R_MOM,  1'b1, 1'b0);
      6'd3:  r = mk(OP_MUL,  R_HH,   R_MOM,   R_T0,   1'b1, 1'b0);
      6'd4:  r = mk(OP_ADD,  R_POS,  R_T0,    R_POS,  1'b1, 1'b0);
      6'd5:  r = mk(OP_MUL,  R_STP,  R_FRIC,  R_T0,   1'b1, 1'b0);
      6'd6:  r = mk(OP_EXP,  R_T0,   R_ZERO,  R_C,    1'b1, 1'b0);
      6'd7:  r = mk(OP_MUL,  R_C,    R_C,     R_T0,   1'b1, 1'b0);
      6'd8:  r = mk(OP_SUB,  R_ONE,  R_T0,    R_T0,   1'b1, 1'b0);
      6'd9:  r = mk(OP_MUL,  R_T0,   R_TEMP,  R_T0,   1'b1, 1'b0);
      6'd10: r = mk(OP_SQRT, R_T0,   R_ZERO,  R_S,    1'b1, 1'b0);
      6'd11: r = mk(OP_MUL,  R_C,    R_MOM,   R_T0,   1'b1, 1'b0);
      6'd12: r = mk(OP_MULN, R_S,    R_NOISE, R_T1,   1'b1, 1'b0);
      6'd13: r = mk(OP_ADD,  R_T0,   R_T1,    R_MOM,  1'b1, 1'b0);
      6'd14: r = mk(OP_MUL,  R_HH,   R_MOM,   R_T0,   1'b1, 1'b0);
      6'd15: r = mk(OP_ADD,  R_POS,  R_T0,    R_POS,  1'b1, 1'b0);
      6'd16: r = mk(OP_MUL,  R_POS,  R_POS,   R_T0,   1'b0, 1'b0);
      6'd17: r = mk(OP_MUL,  R_T0,   R_POS,   R_T0,   1'b0, 1'b0);
      6'd18: r = mk(OP_DIV,  R_ONE,  R_T0,    R_T0,   1'b0, 1'b0);
      6'd19: r = mk(OP_UP,   R_POS,  R_T0,    R_T0,   1'b0, 1'b0);
      6'd20: r = mk(OP_NEG,  R_T0,   R_ZERO,  R_FRC,  1'b0, 1'b0);
      6'd21: r = mk(OP_MUL,  R_HH,   R_FRC,   R_T0,   1'b1, 1'b0);
      6'd22: r = mk(OP_ADD,  R_MOM,  R_T0,    R_MOM,  1'b1, 1'b0);
      6'd23: r = mk(OP_MUL,  R_POS,  R_POS,   R_T0,   1'b0, 1'b0);
      6'd24: r = mk(OP_MUL,  R_T0,   R_POS,   R_T0,   1'b0, 1'b0);
      6'd25: r = mk(OP_MUL,  R_T0,   R_T0,    R_T0,   1'b0, 1'b0);
      6'd26: r = mk(OP_MUL,  R_MIN,  R_MIN,   R_T1,   1'b0, 1'b0);
      6'd27: r = mk(OP_ADD,  R_T0,   R_T1,    R_T0,   1'b0, 1'b0);
      6'd28: r = mk(OP_SQRT, R_T0,   R_ZERO,  R_T0,   1'b0, 1'b0);
      6'd29: r = mk(OP_DIV,  R_ONE,  R_MAX,   R_T1,   1'b0, 1'b0);
      6'd30: r = mk(OP_DIV,  R_ONE,  R_T0,    R_T0,   1'b0, 1'b0);
      6'd31: r = mk(OP_ADD,  R_T1,   R_T0,    R_T0,   1'b0, 1'b0);
      6'd32: r = mk(OP_DIV,  R_ONE,  R_T0,    R_T0,   1'b0, 1'b0);
      6'd33: r = mk(OP_MUL,  R_BASE, R_T0,    R_STP,  1'b0, 1'b0);
      6'd34: r = mk(OP_TADD, R_TIM,  R_STP,   R_TIM,  1'b1, 1'b1);
      default: r = mk(OP_ADD, R_ZERO, R_ZERO, R_ZERO, 1'b0, 1'b1);
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/albs_if.sv =====
`default_nettype none
interface albs_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [15:0] noise;
  modport source (output valid, kind, noise, input ready);
  modport sink   (input valid, kind, noise, output ready);
endinterface

interface albs_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] position;
  logic signed [31:0] momentum;
  logic [30:0]        step_size;
  logic [30:0]        elapsed;
  logic               finished;
  logic               saturated;
  modport source (output valid, position, momentum, step_size, elapsed, finished, saturated,
                  input ready);
  modport sink   (input valid, position, momentum, step_size, elapsed, finished, saturated,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/albs_div.sv =====
`default_nettype none
module albs_div #(
  parameter int NW = 56
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire albs_pkg::div_ctl_t ctl,
  input  wire logic [NW-1:0]    num,
  input  wire logic [31:0]      den,
  output logic                  busy,
  output logic [NW-1:0]         quot
);
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] nreg;
  logic [31:0]   rem;
  logic [31:0]   dreg;
  logic [CW-1:0] cnt;
  logic [32:0]   rs;
  logic [32:0]   rdiff;
  logic          ge;

  assign rs    = {rem, nreg[NW-1]};
  assign rdiff = rs - {1'b0, dreg};
  assign ge    = rs >= {1'b0, dreg};
  assign quot  = nreg;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (ctl.start) begin
      nreg <= ctl.short_mode ? (num << (NW - 31)) : num;
      rem  <= '0;
      dreg <= den;
      cnt  <= ctl.short_mode ? CW'(31) : CW'(NW);
      busy <= 1'b1;
    end else if (busy) begin
      rem  <= ge ? rdiff[31:0] : rs[31:0];
      nreg <= {nreg[NW-2:0], ge};
      cnt  <= cnt - CW'(1);
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/adaptive_langevin_baoab_step_top.sv =====
// channel  dir  handshake     payload
// item     in   valid/ready   kind, noise
// result   out  valid/ready   position, momentum, step_size, elapsed, finished, saturated
// cfg      in   cfg_we        cfg_index, cfg_data
//
// One item at a time through a microcoded sequencer over one 32x32 multiplier,
// a restoring divider (one quotient bit a cycle) and a bit-serial square root.
// Step item time is set by the divider (four divides) and the 20-term exponential series
// (one divide per term), plus one multiply by exp(-1) per whole unit of h*gamma; the
// first step after reset also computes the exp(-1) constant.
// Reset is synchronous; a stalled result waits in its register while the next item runs.
`default_nettype none
module adaptive_langevin_baoab_step_top #(
  parameter int FRAC_BITS = 24
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  albs_in_if.sink          item,
  albs_out_if.source       result
);
  localparam int NW     = 32 + FRAC_BITS;
  localparam int EXP_UP = (FRAC_BITS >= albs_pkg::EXP_FRAC) ? FRAC_BITS - albs_pkg::EXP_FRAC : 0;
  localparam int EXP_DN = (FRAC_BITS <  albs_pkg::EXP_FRAC) ? albs_pkg::EXP_FRAC - FRAC_BITS : 0;
  localparam int EXP_RS = (EXP_DN > 0) ? EXP_DN - 1 : 0;
  localparam logic [31:0] ONE_V = (FRAC_BITS >= 31) ? 32'h7fff_ffff
                                                    : 32'(64'd1 << FRAC_BITS);
  localparam logic [64:0] RND_F  = 65'd1 << (FRAC_BITS - 1);
  localparam logic [64:0] RND_N  = 65'd1 << (albs_pkg::NOISE_FRAC - 1);
  localparam logic [63:0] SQ_LIM = (64'd1 << 62) >> FRAC_BITS;
  localparam logic [63:0] F_MASK = (64'd1 << FRAC_BITS) - 64'd1;
  localparam logic [63:0] RND_E  = (EXP_DN > 0) ? (64'd1 << EXP_RS) : 64'd0;
  localparam logic [31:0] MAX32  = 32'h7fff_ffff;
  localparam logic [31:0] MIN32  = 32'h8000_0000;
  localparam logic [31:0] E_ONE  = 32'h4000_0000;

  function automatic logic [32:0] sat32(input logic signed [75:0] v);
    if (v > 76'sd2147483647) begin
      return {1'b1, MAX32};
    end else if (v < -76'sd2147483648) begin
      return {1'b1, MIN32};
    end
    return {1'b0, v[31:0]};
  endfunction

  logic [30:0] fric, temp, base, mins, maxs, ftime;
  logic [31:0] spos;

  logic signed [31:0] pos, mom, frc, stp, tim, hh, cc, ss, t0, t1;
  logic signed [15:0] nz;
  logic               is_start, clip;
  logic [albs_pkg::PC_W-1:0] pc;
  albs_pkg::state_t   state;
  albs_pkg::uop_t     u;

  logic [31:0] ma, mb;
  logic        neg;
  logic [63:0] prod;
  logic [31:0] xv, sr;
  logic [4:0]  sbit;
  logic [30:0] e1, fx, cx;
  logic        e1_ok, te1;
  logic [31:0] en;
  logic signed [33:0] sum;
  logic [4:0]  kk;

  logic               o_valid;
  logic signed [31:0] o_pos, o_mom;
  logic [30:0]        o_stp, o_tim;
  logic               o_fin, o_sat;

  logic signed [31:0] a, b;
  logic [31:0] mag_a, mag_b;
  logic        skip;
  logic        wb_en, wb_clip, adv;
  logic [31:0] wb_val;

  albs_pkg::div_ctl_t dctl;
  logic [NW-1:0] dnum, quot;
  logic [31:0]   dden;
  logic          dbusy;

  assign u = albs_pkg::uop_at(pc);

  always_comb begin
    unique case (u.a)
      albs_pkg::R_POS:   a = pos;
      albs_pkg::R_MOM:   a = mom;
      albs_pkg::R_FRC:   a = frc;
      albs_pkg::R_STP:   a = stp;
      albs_pkg::R_TIM:   a = tim;
      albs_pkg::R_HH:    a = hh;
      albs_pkg::R_C:     a = cc;
      albs_pkg::R_S:     a = ss;
      albs_pkg::R_T0:    a = t0;
      albs_pkg::R_T1:    a = t1;
      albs_pkg::R_ONE:   a = ONE_V;
      albs_pkg::R_FRIC:  a = {1'b0, fric};
      albs_pkg::R_TEMP:  a = {1'b0, temp};
      albs_pkg::R_BASE:  a = {1'b0, base};
      albs_pkg::R_MIN:   a = {1'b0, mins};
      albs_pkg::R_MAX:   a = {1'b0, maxs};
      albs_pkg::R_NOISE: a = 32'(nz);
      default:           a = '0;
    endcase
    unique case (u.b)
      albs_pkg::R_POS:   b = pos;
      albs_pkg::R_MOM:   b = mom;
      albs_pkg::R_FRC:   b = frc;
      albs_pkg::R_STP:   b = stp;
      albs_pkg::R_TIM:   b = tim;
      albs_pkg::R_HH:    b = hh;
      albs_pkg::R_C:     b = cc;
      albs_pkg::R_S:     b = ss;
      albs_pkg::R_T0:    b = t0;
      albs_pkg::R_T1:    b = t1;
      albs_pkg::R_ONE:   b = ONE_V;
      albs_pkg::R_FRIC:  b = {1'b0, fric};
      albs_pkg::R_TEMP:  b = {1'b0, temp};
      albs_pkg::R_BASE:  b = {1'b0, base};
      albs_pkg::R_MIN:   b = {1'b0, mins};
      albs_pkg::R_MAX:   b = {1'b0, maxs};
      albs_pkg::R_NOISE: b = 32'(nz);
      default:           b = '0;
    endcase
  end

  assign mag_a = a[31] ? (32'd0 - 32'(a)) : 32'(a);
  assign mag_b = b[31] ? (32'd0 - 32'(b)) : 32'(b);
  assign skip  = (state == albs_pkg::S_FETCH) && u.step_only && is_start;

  // datapath results
  logic signed [75:0] sa, sb, t_sum, mval, dval;
  logic [64:0] rsum, rmag;
  logic [32:0] r_add, r_sub, r_up, r_neg, r_mul, r_div;
  logic [31:0] r_half, r_tadd;
  logic        tadd_clip, dbig, sq_ok;
  logic [31:0] rn;
  logic [63:0] ux64, fr30, cf, e_up, e_dn;
  logic [30:0] tq, tcl;
  logic signed [33:0] sum_n;
  logic [32:0] r_exp;

  always_comb begin
    sa = 76'(a);
    sb = 76'(b);
    r_add  = sat32(sa + sb);
    r_sub  = sat32(sa - sb);
    r_up   = sat32((sa <<< 1) - sb);
    r_neg  = sat32(-sa);
    r_half = 32'((sa + 76'sd1) >>> 1);
    t_sum  = sa + sb;
    tadd_clip = 1'b0;
    if (t_sum > 76'sd2147483647) begin
      r_tadd = MAX32;
      tadd_clip = 1'b1;
    end else if (t_sum < 76'sd0) begin
      r_tadd = '0;
    end else begin
      r_tadd = t_sum[31:0];
    end

    rsum = {1'b0, prod} + ((u.op == albs_pkg::OP_MULN) ? RND_N : RND_F);
    rmag = (u.op == albs_pkg::OP_MULN) ? (rsum >> albs_pkg::NOISE_FRAC) : (rsum >> FRAC_BITS);
    mval = neg ? -$signed({11'b0, rmag}) : $signed({11'b0, rmag});
    r_mul = sat32(mval);

    dbig = quot > NW'(64'h8000_0000);
    dval = neg ? -$signed({{(76-NW){1'b0}}, quot}) : $signed({{(76-NW){1'b0}}, quot});
    r_div = dbig ? {1'b1, neg ? MIN32 : MAX32} : sat32(dval);

    sq_ok = (prod >> FRAC_BITS) <= {32'd0, xv};
    rn = sq_ok ? ma : sr;

    ux64 = a[31] ? 64'd0 : {32'd0, a};
    fr30 = (FRAC_BITS >= albs_pkg::EXP_FRAC) ? ((ux64 & F_MASK) >> EXP_UP)
                                             : ((ux64 & F_MASK) << EXP_DN);

    tq = quot[30:0];
    sum_n = kk[0] ? (sum - 34'(tq)) : (sum + 34'(tq));
    if (sum_n < 34'sd0) begin
      tcl = '0;
    end else if (sum_n > 34'sd1073741824) begin
      tcl = 31'h4000_0000;
    end else begin
      tcl = sum_n[30:0];
    end

    cf   = {33'd0, cx};
    e_up = cf << EXP_UP;
    e_dn = (cf + RND_E) >> EXP_DN;
    if (FRAC_BITS >= albs_pkg::EXP_FRAC) begin
      r_exp = (e_up > {32'd0, MAX32}) ? {1'b1, MAX32} : {1'b0, e_up[31:0]};
    end else begin
      r_exp = {1'b0, e_dn[31:0]};
    end
  end

  always_comb begin
    wb_en = 1'b0;
    wb_val = '0;
    wb_clip = 1'b0;
    unique case (state)
      albs_pkg::S_FETCH: begin
        if (!skip) begin
          case (u.op)
            albs_pkg::OP_ADD:  {wb_en, wb_clip, wb_val} = {1'b1, r_add};
            albs_pkg::OP_SUB:  {wb_en, wb_clip, wb_val} = {1'b1, r_sub};
            albs_pkg::OP_UP:   {wb_en, wb_clip, wb_val} = {1'b1, r_up};
            albs_pkg::OP_NEG:  {wb_en, wb_clip, wb_val} = {1'b1, r_neg};
            albs_pkg::OP_HALF: {wb_en, wb_clip, wb_val} = {2'b10, r_half};
            albs_pkg::OP_TADD: {wb_en, wb_clip, wb_val} = {1'b1, tadd_clip, r_tadd};
            albs_pkg::OP_DIV: begin
              if (b == 32'sd0) begin
                {wb_en, wb_clip, wb_val} = {2'b11, a[31] ? MIN32 : MAX32};
              end
            end
            albs_pkg::OP_SQRT: begin
              if (a <= 32'sd0) begin
                {wb_en, wb_clip, wb_val} = {2'b10, 32'd0};
              end else if ({32'd0, a} >= SQ_LIM) begin
                {wb_en, wb_clip, wb_val} = {2'b11, MAX32};
              end
            end
            default: ;
          endcase
        end
      end
      albs_pkg::S_MULR: {wb_en, wb_clip, wb_val} = {1'b1, r_mul};
      albs_pkg::S_DIVW: begin
        if (!dbusy) begin
          {wb_en, wb_clip, wb_val} = {1'b1, r_div};
        end
      end
      albs_pkg::S_SQC: begin
        if (sbit == 5'd0) begin
          {wb_en, wb_clip, wb_val} = {2'b10, rn};
        end
      end
      albs_pkg::S_EXL: begin
        if (en == 32'd0 || cx == 31'd0) begin
          {wb_en, wb_clip, wb_val} = {1'b1, r_exp};
        end
      end
      default: ;
    endcase
  end

  assign adv = wb_en | skip;

  assign dctl.start      = (state == albs_pkg::S_DIVL) || (state == albs_pkg::S_TDL);
  assign dctl.short_mode = (state == albs_pkg::S_TDL);
  assign dnum = (state == albs_pkg::S_TDL) ? NW'(prod >> albs_pkg::EXP_FRAC)
                                           : {ma, {FRAC_BITS{1'b0}}};
  assign dden = (state == albs_pkg::S_TDL) ? 32'(kk) : mb;

  albs_div #(.NW(NW)) u_div (
    .clk  (clk),
    .rst  (rst),
    .ctl  (dctl),
    .num  (dnum),
    .den  (dden),
    .busy (dbusy),
    .quot (quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= albs_pkg::S_IDLE;
      pc       <= albs_pkg::PC_STEP;
      o_valid  <= 1'b0;
      e1_ok    <= 1'b0;
      te1      <= 1'b0;
      is_start <= 1'b0;
      clip     <= 1'b0;
      fric     <= 31'd1677722;
      temp     <= 31'd167772;
      base     <= 31'd1677722;
      mins     <= 31'd167772;
      maxs     <= 31'd16777216;
      spos     <= 32'd33554432;
      ftime    <= 31'd1677721600;
      pos      <= 32'sd33554432;
      mom      <= '0;
      frc      <= '0;
      stp      <= '0;
      tim      <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          albs_pkg::REG_FRIC:  fric  <= cfg_data[30:0];
          albs_pkg::REG_TEMP:  temp  <= cfg_data[30:0];
          albs_pkg::REG_BASE:  base  <= cfg_data[30:0];
          albs_pkg::REG_MIN:   mins  <= cfg_data[30:0];
          albs_pkg::REG_MAX:   maxs  <= cfg_data[30:0];
          albs_pkg::REG_START: spos  <= cfg_data;
          albs_pkg::REG_FINAL: ftime <= cfg_data[30:0];
          default: ;
        endcase
      end

      if (o_valid && result.ready && (state != albs_pkg::S_OUT)) begin
        o_valid <= 1'b0;
      end

      if (wb_en) begin
        case (u.d)
          albs_pkg::R_POS: pos <= wb_val;
          albs_pkg::R_MOM: mom <= wb_val;
          albs_pkg::R_FRC: frc <= wb_val;
          albs_pkg::R_STP: stp <= wb_val;
          albs_pkg::R_TIM: tim <= wb_val;
          albs_pkg::R_HH:  hh  <= wb_val;
          albs_pkg::R_C:   cc  <= wb_val;
          albs_pkg::R_S:   ss  <= wb_val;
          albs_pkg::R_T0:  t0  <= wb_val;
          albs_pkg::R_T1:  t1  <= wb_val;
          default: ;
        endcase
        if (wb_clip) begin
          clip <= 1'b1;
        end
      end

      unique case (state)
        albs_pkg::S_IDLE: begin
          if (item.valid) begin
            is_start <= !item.kind;
            nz       <= item.noise;
            clip     <= 1'b0;
            if (!item.kind) begin
              pos <= spos;
              mom <= '0;
              tim <= '0;
              pc  <= albs_pkg::PC_START;
            end else begin
              pc  <= albs_pkg::PC_STEP;
            end
            state <= albs_pkg::S_FETCH;
          end
        end
        albs_pkg::S_FETCH: begin
          if (!adv) begin
            case (u.op)
              albs_pkg::OP_MUL, albs_pkg::OP_MULN: begin
                ma    <= mag_a;
                mb    <= mag_b;
                neg   <= a[31] ^ b[31];
                state <= albs_pkg::S_MUL;
              end
              albs_pkg::OP_DIV: begin
                ma    <= mag_a;
                mb    <= mag_b;
                neg   <= a[31] ^ b[31];
                state <= albs_pkg::S_DIVL;
              end
              albs_pkg::OP_SQRT: begin
                xv    <= a;
                ma    <= E_ONE;
                mb    <= E_ONE;
                sr    <= '0;
                sbit  <= 5'd30;
                state <= albs_pkg::S_SQM;
              end
              albs_pkg::OP_EXP: begin
                en    <= 32'(ux64 >> FRAC_BITS);
                fx    <= fr30[30:0];
                ma    <= E_ONE;
                mb    <= e1_ok ? {1'b0, fr30[30:0]} : E_ONE;
                sum   <= 34'sd1073741824;
                kk    <= 5'd1;
                te1   <= !e1_ok;
                state <= albs_pkg::S_TMUL;
              end
              default: ;
            endcase
          end
        end
        albs_pkg::S_MUL: begin
          prod  <= ma * mb;
          state <= albs_pkg::S_MULR;
        end
        albs_pkg::S_MULR: ;
        albs_pkg::S_DIVL: state <= albs_pkg::S_DIVW;
        albs_pkg::S_DIVW: ;
        albs_pkg::S_SQM: begin
          prod  <= ma * mb;
          state <= albs_pkg::S_SQC;
        end
        albs_pkg::S_SQC: begin
          if (sbit != 5'd0) begin
            sr    <= rn;
            sbit  <= sbit - 5'd1;
            ma    <= rn | (32'd1 << (sbit - 5'd1));
            mb    <= rn | (32'd1 << (sbit - 5'd1));
            state <= albs_pkg::S_SQM;
          end
        end
        albs_pkg::S_TMUL: begin
          prod  <= ma * mb;
          state <= albs_pkg::S_TDL;
        end
        albs_pkg::S_TDL: state <= albs_pkg::S_TDW;
        albs_pkg::S_TDW: begin
          if (!dbusy) begin
            if (kk == 5'(albs_pkg::TAYLOR_N)) begin
              if (te1) begin
                e1    <= tcl;
                e1_ok <= 1'b1;
                te1   <= 1'b0;
                ma    <= E_ONE;
                mb    <= {1'b0, fx};
                sum   <= 34'sd1073741824;
                kk    <= 5'd1;
                state <= albs_pkg::S_TMUL;
              end else begin
                cx    <= tcl;
                state <= albs_pkg::S_EXL;
              end
            end else begin
              sum   <= sum_n;
              kk    <= kk + 5'd1;
              ma    <= {1'b0, tq};
              state <= albs_pkg::S_TMUL;
            end
          end
        end
        albs_pkg::S_EXL: begin
          if (!adv) begin
            ma    <= {1'b0, cx};
            mb    <= {1'b0, e1};
            state <= albs_pkg::S_EXM;
          end
        end
        albs_pkg::S_EXM: begin
          prod  <= ma * mb;
          state <= albs_pkg::S_EXR;
        end
        albs_pkg::S_EXR: begin
          cx    <= 31'((prod + 64'h2000_0000) >> albs_pkg::EXP_FRAC);
          en    <= en - 32'd1;
          state <= albs_pkg::S_EXL;
        end
        albs_pkg::S_OUT: begin
          if (!o_valid || result.ready) begin
            o_valid <= 1'b1;
            o_pos   <= pos;
            o_mom   <= mom;
            o_stp   <= stp[30:0];
            o_tim   <= tim[30:0];
            o_fin   <= tim[30:0] >= ftime;
            o_sat   <= clip;
            state   <= albs_pkg::S_IDLE;
          end
        end
        default: state <= albs_pkg::S_IDLE;
      endcase

      if (adv) begin
        if (u.last) begin
          state <= albs_pkg::S_OUT;
        end else begin
          pc    <= pc + albs_pkg::PC_W'(1);
          state <= albs_pkg::S_FETCH;
        end
      end
    end
  end

  assign item.ready       = (state == albs_pkg::S_IDLE);
  assign result.valid     = o_valid;
  assign result.position  = o_pos;
  assign result.momentum  = o_mom;
  assign result.step_size = o_stp;
  assign result.elapsed   = o_tim;
  assign result.finished  = o_fin;
  assign result.saturated = o_sat;
endmodule
`default_nettype wire

// ===== rtl/albs_chk.sv =====
`default_nettype none
module albs_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        item_valid,
  input wire logic        item_ready,
  input wire logic        res_valid,
  input wire logic        res_ready,
  input wire logic [31:0] position,
  input wire logic [31:0] momentum
);
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while stalled");

  a_res_stable: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable(position) && $stable(momentum))
    else $error("result payload changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("item taken while previous item still in work");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");
endmodule

bind adaptive_langevin_baoab_step_top albs_chk u_albs_chk (
  .clk        (clk),
  .rst        (rst),
  .item_valid (item.valid),
  .item_ready (item.ready),
  .res_valid  (result.valid),
  .res_ready  (result.ready),
  .position   (result.position),
  .momentum   (result.momentum)
);
`default_nettype wire
